// ----- hdl/bmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsd_pkg
// shared types and constants of the blob merge / split detector
// ----------------------------------------------------------------------------
package bmsd_pkg;

  // default configuration
  localparam int SLOTS_DEF      = 16;
  localparam int COORD_BITS_DEF = 12;

  // field widths fixed by the stream format
  localparam int FIELD_W     = 12;
  localparam int IDX_FIELD_W = 4;
  localparam int OP_W        = 3;
  localparam int THR_W       = 24;
  localparam int MASK_W      = 16;
  localparam int COUNT_W     = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_PREV = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_CUR  = 3'd2;
  localparam logic [OP_W-1:0] OP_MERGE     = 3'd3;
  localparam logic [OP_W-1:0] OP_SPLIT     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_J,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input transfer
    logic start;     // decode: clear, load, error check, reset accumulators
    logic rd_j;      // pair read address selects the second index
    logic latch_a;   // take first pair rectangle from read data
    logic latch_b;   // take second pair rectangle from read data
    logic scan_clr;  // rewind scan index
    logic scan_rd;   // read other set at scan index and advance
    logic emit;      // move result into output register
  } bmsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic test_go;    // valid merge or split test
    logic scan_last;  // scan index at last entry of other set
    logic busy;       // overlap pipeline holds work
    logic out_free;   // output register can take a result
  } bmsd_sts_t;

endpackage

// ----- hdl/blob_merge_split_detector_top.sv -----
// ----------------------------------------------------------------------------
// blob_merge_split_detector_top
// merge / split test of tracked rectangles against current-frame blobs
// ----------------------------------------------------------------------------
// The block stores up to SLOTS previous-frame rectangles and up to SLOTS
// current-frame rectangles. Each input transfer is one operation and gives
// exactly one result transfer. Clear, load and any operation that fails its
// checks go from decode straight to the result hand-off; a merge or split
// test also scans the set the mask runs over: the other set's store is read
// one entry per cycle through its single registered read port, and each
// entry passes a two-stage overlap pipeline (axis overlaps, then two area
// multiplies against the threshold) before the mask settles. A finished
// result sits in the output register while the next operation is accepted.
// The user must write the threshold through cfg_wr_en and cfg_wr_data only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module blob_merge_split_detector_top #(
  parameter int SLOTS      = bmsd_pkg::SLOTS_DEF,
  parameter int COORD_BITS = bmsd_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // operation stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // rect_x, rect_y, rect_width, rect_height, first_index, second_index
  input  logic [55:0] in_tdata,
  // operation
  input  logic [2:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // match_mask, match_count, zero fill
  output logic [23:0] out_tdata,
  // error_flag
  output logic [0:0]  out_tuser,
  // threshold register
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);

  bmsd_pkg::bmsd_cmd_t cmd;
  bmsd_pkg::bmsd_sts_t sts;

  logic [bmsd_pkg::MASK_W-1:0]  match_mask;
  logic [bmsd_pkg::COUNT_W-1:0] match_count;
  logic                         error_flag;

  // sequencer
  bmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, overlap pipeline and result register
  bmsd_dp #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .operation    (in_tuser),
    .rect_x       (in_tdata[11:0]),
    .rect_y       (in_tdata[23:12]),
    .rect_width   (in_tdata[35:24]),
    .rect_height  (in_tdata[47:36]),
    .first_index  (in_tdata[51:48]),
    .second_index (in_tdata[55:52]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .match_mask   (match_mask),
    .match_count  (match_count),
    .error_flag   (error_flag)
  );

  // result packing, lowest field first
  assign out_tdata = {3'b000, match_count, match_mask};
  assign out_tuser = error_flag;

endmodule

// ----- hdl/bmsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmsd_ctrl
// sequencer: decode, pair fetch, scan of the other set, drain, result hand-off
// ----------------------------------------------------------------------------
module bmsd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bmsd_pkg::bmsd_sts_t sts,
  output bmsd_pkg::bmsd_cmd_t cmd
);

  bmsd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmsd_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = bmsd_pkg::ST_DECODE;
      end
      bmsd_pkg::ST_DECODE: begin
        if (sts.test_go) state_nxt = bmsd_pkg::ST_READ_J;
        else             state_nxt = bmsd_pkg::ST_DONE;
      end
      bmsd_pkg::ST_READ_J: begin
        state_nxt = bmsd_pkg::ST_SCAN;
      end
      bmsd_pkg::ST_SCAN: begin
        if (sts.scan_last) state_nxt = bmsd_pkg::ST_DRAIN;
      end
      bmsd_pkg::ST_DRAIN: begin
        if (!sts.busy) state_nxt = bmsd_pkg::ST_DONE;
      end
      bmsd_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = bmsd_pkg::ST_IDLE;
      end
      default: state_nxt = bmsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bmsd_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      bmsd_pkg::ST_DECODE: begin
        cmd.start = 1'b1;
      end
      bmsd_pkg::ST_READ_J: begin
        cmd.latch_a  = 1'b1;
        cmd.rd_j     = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      bmsd_pkg::ST_SCAN: begin
        // pair address stays on j so the read data keeps the second rect
        cmd.rd_j    = 1'b1;
        cmd.latch_b = 1'b1;
        cmd.scan_rd = 1'b1;
      end
      bmsd_pkg::ST_DRAIN: begin
        cmd.rd_j = 1'b1;
      end
      bmsd_pkg::ST_DONE: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/bmsd_dp.sv -----
// ----------------------------------------------------------------------------
// bmsd_dp
// rectangle stores, overlap pipeline, result accumulators and output register
// ----------------------------------------------------------------------------
module bmsd_dp #(
  parameter int SLOTS      = bmsd_pkg::SLOTS_DEF,
  parameter int COORD_BITS = bmsd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // captured on an input transfer
  input  logic [bmsd_pkg::OP_W-1:0]           operation,
  input  logic [bmsd_pkg::FIELD_W-1:0]        rect_x,
  input  logic [bmsd_pkg::FIELD_W-1:0]        rect_y,
  input  logic [bmsd_pkg::FIELD_W-1:0]        rect_width,
  input  logic [bmsd_pkg::FIELD_W-1:0]        rect_height,
  input  logic [bmsd_pkg::IDX_FIELD_W-1:0]    first_index,
  input  logic [bmsd_pkg::IDX_FIELD_W-1:0]    second_index,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [bmsd_pkg::THR_W-1:0]          cfg_wr_data,
  // control
  input  bmsd_pkg::bmsd_cmd_t                 cmd,
  output bmsd_pkg::bmsd_sts_t                 sts,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmsd_pkg::MASK_W-1:0]         match_mask,
  output logic [bmsd_pkg::COUNT_W-1:0]        match_count,
  output logic                                error_flag
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int RECT_W = 4 * COORD_BITS;
  localparam int EDGE_W = COORD_BITS + 1;
  localparam int AREA_W = 2 * EDGE_W;
  localparam int CMP_W  = (AREA_W > bmsd_pkg::THR_W) ? AREA_W : bmsd_pkg::THR_W;
  localparam int IC_W   = CNT_W + bmsd_pkg::IDX_FIELD_W;

  // overlap length along one axis, zero when disjoint
  function automatic logic [EDGE_W-1:0] span(
    input logic [COORD_BITS-1:0] a_lo,
    input logic [COORD_BITS-1:0] a_len,
    input logic [COORD_BITS-1:0] b_lo,
    input logic [COORD_BITS-1:0] b_len
  );
    logic [EDGE_W-1:0] a_end;
    logic [EDGE_W-1:0] b_end;
    logic [EDGE_W-1:0] lo;
    logic [EDGE_W-1:0] hi;
    a_end = EDGE_W'(a_lo) + EDGE_W'(a_len);
    b_end = EDGE_W'(b_lo) + EDGE_W'(b_len);
    lo    = (a_lo > b_lo) ? EDGE_W'(a_lo) : EDGE_W'(b_lo);
    hi    = (a_end < b_end) ? a_end : b_end;
    return (hi > lo) ? (hi - lo) : '0;
  endfunction

  // captured item
  logic [bmsd_pkg::OP_W-1:0]        op_r;
  logic [bmsd_pkg::IDX_FIELD_W-1:0] i_r, j_r;
  logic [RECT_W-1:0]                new_rect_r;

  // stores
  logic [RECT_W-1:0] prev_mem [SLOTS];
  logic [RECT_W-1:0] cur_mem  [SLOTS];
  logic [RECT_W-1:0] prev_q_r, cur_q_r;
  logic [CNT_W-1:0]  prev_cnt_r, cur_cnt_r;
  logic [bmsd_pkg::THR_W-1:0] thr_r;

  // scan and pipeline
  logic [IDX_W-1:0]  k_r, k1_r, k2_r;
  logic              v1_r, v2_r;
  logic [RECT_W-1:0] pa_r, pb_r;
  logic [EDGE_W-1:0] dxa_r, dya_r, dxb_r, dyb_r;

  // accumulators and output
  logic [bmsd_pkg::MASK_W-1:0]  mask_r;
  logic [bmsd_pkg::COUNT_W-1:0] cnt_r;
  logic                         err_r;
  logic                         out_valid_r;
  logic [bmsd_pkg::MASK_W-1:0]  out_mask_r;
  logic [bmsd_pkg::COUNT_W-1:0] out_cnt_r;
  logic                         out_err_r;

  logic              merge;
  logic [CNT_W-1:0]  pair_cnt, other_cnt;
  logic [IDX_W-1:0]  pair_addr, prev_addr, cur_addr, other_last;
  logic [RECT_W-1:0] pair_q, other_q;
  logic              is_test, pair_bad, err_c;
  logic              prev_we, cur_we;
  logic [AREA_W-1:0] area_a, area_b;
  logic              hit;

  assign merge     = (op_r == bmsd_pkg::OP_MERGE);
  assign pair_cnt  = merge ? prev_cnt_r : cur_cnt_r;
  assign other_cnt = merge ? cur_cnt_r : prev_cnt_r;
  assign pair_addr = cmd.rd_j ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign prev_addr = merge ? pair_addr : k_r;
  assign cur_addr  = merge ? k_r : pair_addr;
  assign pair_q    = merge ? prev_q_r : cur_q_r;
  assign other_q   = merge ? cur_q_r : prev_q_r;
  assign other_last = IDX_W'(other_cnt - CNT_W'(1));

  assign is_test  = (op_r == bmsd_pkg::OP_MERGE) || (op_r == bmsd_pkg::OP_SPLIT);
  assign pair_bad = (i_r >= j_r) || (IC_W'(j_r) >= IC_W'(pair_cnt));

  always_comb begin
    unique case (op_r)
      bmsd_pkg::OP_CLEAR:     err_c = 1'b0;
      bmsd_pkg::OP_LOAD_PREV: err_c = (prev_cnt_r >= CNT_W'(SLOTS));
      bmsd_pkg::OP_LOAD_CUR:  err_c = (cur_cnt_r >= CNT_W'(SLOTS));
      bmsd_pkg::OP_MERGE,
      bmsd_pkg::OP_SPLIT:     err_c = pair_bad || (other_cnt == '0);
      default:                err_c = 1'b1;
    endcase
  end

  assign prev_we = cmd.start && (op_r == bmsd_pkg::OP_LOAD_PREV) && !err_c;
  assign cur_we  = cmd.start && (op_r == bmsd_pkg::OP_LOAD_CUR) && !err_c;

  // stage two: areas against the threshold
  assign area_a = dxa_r * dya_r;
  assign area_b = dxb_r * dyb_r;
  assign hit    = (CMP_W'(area_a) > CMP_W'(thr_r)) && (CMP_W'(area_b) > CMP_W'(thr_r));

  assign sts.test_go   = is_test && !err_c;
  assign sts.scan_last = (k_r == other_last);
  assign sts.busy      = v1_r || v2_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign match_mask  = out_mask_r;
  assign match_count = out_cnt_r;
  assign error_flag  = out_err_r;

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_cnt_r[IDX_W-1:0]] <= new_rect_r;
    prev_q_r <= prev_mem[prev_addr];
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_cnt_r[IDX_W-1:0]] <= new_rect_r;
    cur_q_r <= cur_mem[cur_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cnt_r  <= '0;
      cur_cnt_r   <= '0;
      thr_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (cmd.start && (op_r == bmsd_pkg::OP_CLEAR)) begin
        prev_cnt_r <= '0;
        cur_cnt_r  <= '0;
      end
      if (prev_we) prev_cnt_r <= prev_cnt_r + CNT_W'(1);
      if (cur_we)  cur_cnt_r  <= cur_cnt_r + CNT_W'(1);
      v1_r <= cmd.scan_rd;
      v2_r <= v1_r;
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= operation;
      i_r        <= first_index;
      j_r        <= second_index;
      new_rect_r <= {COORD_BITS'(rect_height), COORD_BITS'(rect_width),
                     COORD_BITS'(rect_y), COORD_BITS'(rect_x)};
    end
    if (cmd.scan_clr)     k_r <= '0;
    else if (cmd.scan_rd) k_r <= k_r + IDX_W'(1);
    k1_r <= k_r;
    k2_r <= k1_r;
    if (cmd.latch_a) pa_r <= pair_q;
    if (cmd.latch_b) pb_r <= pair_q;
    // stage one: axis overlaps of the other rect with both pair rects
    dxa_r <= span(pa_r[COORD_BITS-1:0], pa_r[3*COORD_BITS-1:2*COORD_BITS],
                  other_q[COORD_BITS-1:0], other_q[3*COORD_BITS-1:2*COORD_BITS]);
    dya_r <= span(pa_r[2*COORD_BITS-1:COORD_BITS], pa_r[4*COORD_BITS-1:3*COORD_BITS],
                  other_q[2*COORD_BITS-1:COORD_BITS],
                  other_q[4*COORD_BITS-1:3*COORD_BITS]);
    dxb_r <= span(pb_r[COORD_BITS-1:0], pb_r[3*COORD_BITS-1:2*COORD_BITS],
                  other_q[COORD_BITS-1:0], other_q[3*COORD_BITS-1:2*COORD_BITS]);
    dyb_r <= span(pb_r[2*COORD_BITS-1:COORD_BITS], pb_r[4*COORD_BITS-1:3*COORD_BITS],
                  other_q[2*COORD_BITS-1:COORD_BITS],
                  other_q[4*COORD_BITS-1:3*COORD_BITS]);
    if (cmd.start) begin
      mask_r <= '0;
      cnt_r  <= '0;
      err_r  <= err_c;
    end else if (v2_r && hit) begin
      mask_r <= mask_r | (bmsd_pkg::MASK_W'(1) << k2_r);
      cnt_r  <= cnt_r + bmsd_pkg::COUNT_W'(1);
    end
    if (cmd.emit) begin
      out_mask_r <= mask_r;
      out_cnt_r  <= cnt_r;
      out_err_r  <= err_r;
    end
  end

endmodule

// ----- dv/bmsd_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsd_result_checker
// watches the operation, result and threshold ports of the blob merge / split
// detector, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module bmsd_result_checker #(
  parameter int SLOTS = bmsd_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  output int          mismatch_count,
  output int          results_awaited
);

  typedef struct packed {
    logic [bmsd_pkg::FIELD_W-1:0] x;
    logic [bmsd_pkg::FIELD_W-1:0] y;
    logic [bmsd_pkg::FIELD_W-1:0] w;
    logic [bmsd_pkg::FIELD_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic [bmsd_pkg::MASK_W-1:0]  mask;
    logic [bmsd_pkg::COUNT_W-1:0] count;
    logic                         err;
  } match_result_t;

  rect_t                       prev_rects [SLOTS];
  rect_t                       cur_rects  [SLOTS];
  int                          prev_n;
  int                          cur_n;
  logic [bmsd_pkg::THR_W-1:0]  threshold;
  match_result_t               awaited_q [$];

  initial begin
    mismatch_count  = 0;
    results_awaited = 0;
  end

  // clipped box area, zero when the boxes do not meet
  function automatic int unsigned overlap_area(rect_t a, rect_t b);
    int unsigned lo_x, lo_y, hi_x, hi_y, a_x2, a_y2, b_x2, b_y2;
    lo_x = (a.x > b.x) ? a.x : b.x;
    lo_y = (a.y > b.y) ? a.y : b.y;
    a_x2 = a.x + a.w;
    b_x2 = b.x + b.w;
    a_y2 = a.y + a.h;
    b_y2 = b.y + b.h;
    hi_x = (a_x2 < b_x2) ? a_x2 : b_x2;
    hi_y = (a_y2 < b_y2) ? a_y2 : b_y2;
    if (hi_x <= lo_x || hi_y <= lo_y) return 0;
    return (hi_x - lo_x) * (hi_y - lo_y);
  endfunction

  // merge takes the pair from the previous set, split from the current set
  function automatic match_result_t pair_test(bit merge, int i, int j);
    match_result_t r;
    rect_t         a, b, c;
    int            pair_n, other_n;
    r       = '0;
    pair_n  = merge ? prev_n : cur_n;
    other_n = merge ? cur_n : prev_n;
    if (i >= j || j >= pair_n || other_n == 0) begin
      r.err = 1'b1;
      return r;
    end
    a = merge ? prev_rects[i] : cur_rects[i];
    b = merge ? prev_rects[j] : cur_rects[j];
    for (int k = 0; k < other_n; k++) begin
      c = merge ? cur_rects[k] : prev_rects[k];
      if (overlap_area(a, c) > threshold && overlap_area(b, c) > threshold)
        r.mask[k] = 1'b1;
    end
    r.count = bmsd_pkg::COUNT_W'($countones(r.mask));
    return r;
  endfunction

  function automatic match_result_t apply_operation(logic [2:0] op, logic [55:0] data);
    match_result_t r;
    rect_t         box;
    int            i, j;
    r     = '0;
    box.x = data[11:0];
    box.y = data[23:12];
    box.w = data[35:24];
    box.h = data[47:36];
    i     = int'(data[51:48]);
    j     = int'(data[55:52]);
    case (op)
      bmsd_pkg::OP_CLEAR: begin
        prev_n = 0;
        cur_n  = 0;
      end
      bmsd_pkg::OP_LOAD_PREV: begin
        if (prev_n >= SLOTS) r.err = 1'b1;
        else begin
          prev_rects[prev_n] = box;
          prev_n++;
        end
      end
      bmsd_pkg::OP_LOAD_CUR: begin
        if (cur_n >= SLOTS) r.err = 1'b1;
        else begin
          cur_rects[cur_n] = box;
          cur_n++;
        end
      end
      bmsd_pkg::OP_MERGE: r = pair_test(1'b1, i, j);
      bmsd_pkg::OP_SPLIT: r = pair_test(1'b0, i, j);
      default: r.err = 1'b1;
    endcase
    return r;
  endfunction

  task automatic flag_failure(string msg);
    if (mismatch_count < 10) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    match_result_t got, want;
    if (!rst_n) begin
      prev_n    = 0;
      cur_n     = 0;
      threshold = '0;
      awaited_q.delete();
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (in_tvalid && in_tready)
        awaited_q.insert(awaited_q.size(), apply_operation(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.mask  = out_tdata[15:0];
        got.count = out_tdata[20:16];
        got.err   = out_tuser[0];
        if (awaited_q.size() == 0) begin
          flag_failure($sformatf("unexpected result mask %h count %0d err %0d",
                                 got.mask, got.count, got.err));
        end else begin
          want = awaited_q.pop_front();
          if (got !== want)
            flag_failure($sformatf({"result mismatch: expected mask %h count %0d err %0d,",
                                    " got mask %h count %0d err %0d"},
                                   want.mask, want.count, want.err,
                                   got.mask, got.count, got.err));
        end
      end
    end
    results_awaited = awaited_q.size();
  end

endmodule

// ----- dv/tb_blob_merge_split_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blob_merge_split_detector_top
// stimulus and verdict for the blob merge / split detector: a directed set of
// corner cases, then random scenes of loaded rectangles followed by merge and
// split tests, under several overlap thresholds with random stalls on both
// streams; result checking is done by bmsd_result_checker
// ----------------------------------------------------------------------------
module tb_blob_merge_split_detector_top;

  localparam int SLOTS = bmsd_pkg::SLOTS_DEF;
  // items per random phase, six phases after the directed part
  localparam int PHASE_ITEMS = 312;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;  // rect_x, rect_y, rect_width, rect_height, first_index, second_index
  logic [2:0]  in_tuser;  // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata; // match_mask, match_count, zero fill
  logic [0:0]  out_tuser; // error_flag
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;

  int mismatch_count;
  int results_awaited;

  // stimulus bookkeeping: how many rects each set holds, used to form valid pairs
  int prev_loaded;
  int cur_loaded;
  int items_sent;
  // remaining transfers of a stretch with no idling, per side
  int send_quiet;
  int take_quiet;

  blob_merge_split_detector_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bmsd_result_checker #(.SLOTS(SLOTS)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // random wait before the next transfer, with occasional stretches of none
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) quiet_left = int'($urandom_range(10, 40));
    return int'($urandom_range(0, 18));
  endfunction

  function automatic logic [11:0] rand12();
    return 12'($urandom);
  endfunction

  // rects in a set for one scene: mostly a few, sometimes none, sometimes near or past SLOTS
  function automatic int scene_size();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return int'($urandom_range(SLOTS - 1, SLOTS + 2));
    if (r == 1) return 0;
    return int'($urandom_range(1, 8));
  endfunction

  // one transfer on the operation stream, called and returning at a falling edge
  task automatic send_op(input logic [2:0] op, input logic [11:0] x, input logic [11:0] y,
                         input logic [11:0] w, input logic [11:0] h,
                         input logic [3:0] i, input logic [3:0] j);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {j, i, h, w, y, x};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
    case (op)
      bmsd_pkg::OP_CLEAR: begin
        prev_loaded = 0;
        cur_loaded  = 0;
      end
      bmsd_pkg::OP_LOAD_PREV: if (prev_loaded < SLOTS) prev_loaded++;
      bmsd_pkg::OP_LOAD_CUR:  if (cur_loaded < SLOTS) cur_loaded++;
      default: ;
    endcase
  endtask

  // hold the operation stream until every expected result has come back
  task automatic wait_idle();
    int waited;
    waited    = 0;
    in_tvalid = 1'b0;
    while (results_awaited != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (30) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [23:0] value);
    wait_idle();
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    @(negedge clk);
  endtask

  // a scene: mostly a clear first, load both sets around one spot, then a burst of pair tests
  task automatic run_scene();
    int          n_prev, n_cur, n_tests, spread, pair_n, r;
    logic [11:0] bx, by, x, y, w, h;
    logic [3:0]  i, j;
    logic [2:0]  op;
    if ($urandom_range(0, 9) != 0)
      send_op(bmsd_pkg::OP_CLEAR, rand12(), rand12(), rand12(), rand12(),
              4'($urandom), 4'($urandom));
    r      = int'($urandom_range(0, 2));
    spread = (r == 0) ? 16 : (r == 1) ? 320 : 4095;
    bx     = rand12();
    by     = rand12();
    n_prev = scene_size();
    n_cur  = scene_size();
    while (n_prev + n_cur > 0) begin
      if (n_prev > 0 && (n_cur == 0 || $urandom_range(0, 1) == 0)) begin
        op = bmsd_pkg::OP_LOAD_PREV;
        n_prev--;
      end else begin
        op = bmsd_pkg::OP_LOAD_CUR;
        n_cur--;
      end
      if ($urandom_range(0, 7) == 0) begin
        // a stray rect anywhere on the plane
        x = rand12();
        y = rand12();
        w = rand12();
        h = rand12();
      end else begin
        // offsets up to half the spread, sizes at least half of it, keep most of the cluster overlapping
        x = 12'(bx + 12'($urandom_range(0, spread / 2)));
        y = 12'(by + 12'($urandom_range(0, spread / 2)));
        w = 12'($urandom_range(spread / 2, spread));
        h = 12'($urandom_range(spread / 2, spread));
      end
      send_op(op, x, y, w, h, 4'($urandom), 4'($urandom));
    end
    n_tests = int'($urandom_range(2, 12));
    repeat (n_tests) begin
      op     = ($urandom_range(0, 1) == 0) ? bmsd_pkg::OP_MERGE : bmsd_pkg::OP_SPLIT;
      pair_n = (op == bmsd_pkg::OP_MERGE) ? prev_loaded : cur_loaded;
      if (pair_n >= 2 && $urandom_range(0, 4) != 0) begin
        i = 4'($urandom_range(0, pair_n - 2));
        j = 4'($urandom_range(int'(i) + 1, pair_n - 1));
      end else begin
        i = 4'($urandom);
        j = 4'($urandom);
      end
      send_op(op, rand12(), rand12(), rand12(), rand12(), i, j);
    end
    // noise: any code, unknown ones included
    repeat ($urandom_range(0, 2))
      send_op(3'($urandom), rand12(), rand12(), rand12(), rand12(),
              4'($urandom), 4'($urandom));
  endtask

  // result side: ready drops for a random stall, sometimes none, before each transfer
  initial begin
    int stall;
    out_tready = 1'b0;
    take_quiet = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_wait(take_quiet);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    logic [23:0] phase_threshold [6];
    int          phase_end;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = bmsd_pkg::OP_CLEAR;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    prev_loaded = 0;
    cur_loaded  = 0;
    items_sent  = 0;
    send_quiet  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part, threshold zero: any overlap at all counts
    write_threshold(24'd0);
    send_op(bmsd_pkg::OP_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0);
    // tests against empty sets
    send_op(bmsd_pkg::OP_MERGE, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 4'd1);
    send_op(bmsd_pkg::OP_SPLIT, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 4'd0, 4'd1);
    // zero-size rect, largest rect at the far corner, two overlapping boxes
    send_op(bmsd_pkg::OP_LOAD_PREV, 12'd0, 12'd0, 12'd0, 12'd0, 4'hf, 4'hf);
    send_op(bmsd_pkg::OP_LOAD_PREV, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 4'd0, 4'd0);
    send_op(bmsd_pkg::OP_LOAD_PREV, 12'd100, 12'd100, 12'd200, 12'd200, 4'd0, 4'd0);
    send_op(bmsd_pkg::OP_LOAD_PREV, 12'd150, 12'd150, 12'd200, 12'd200, 4'd0, 4'd0);
    send_op(bmsd_pkg::OP_LOAD_CUR, 12'd120, 12'd120, 12'd100, 12'd100, 4'd0, 4'd0);
    send_op(bmsd_pkg::OP_LOAD_CUR, 12'd0, 12'd0, 12'hfff, 12'hfff, 4'd0, 4'd0);
    // touches the right edge of the plane, one pixel wide
    send_op(bmsd_pkg::OP_LOAD_CUR, 12'hfff, 12'd0, 12'd1, 12'hfff, 4'd0, 4'd0);
    // edge-adjacent to the first current box: zero area
    send_op(bmsd_pkg::OP_LOAD_CUR, 12'd220, 12'd120, 12'd50, 12'd50, 4'd0, 4'd0);
    send_op(bmsd_pkg::OP_MERGE, 12'd0, 12'd0, 12'd0, 12'd0, 4'd2, 4'd3);
    send_op(bmsd_pkg::OP_MERGE, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 4'd1);
    // invalid pairs: equal, reversed, second beyond the set
    send_op(bmsd_pkg::OP_MERGE, 12'd0, 12'd0, 12'd0, 12'd0, 4'd3, 4'd3);
    send_op(bmsd_pkg::OP_MERGE, 12'd0, 12'd0, 12'd0, 12'd0, 4'd3, 4'd2);
    send_op(bmsd_pkg::OP_MERGE, 12'd0, 12'd0, 12'd0, 12'd0, 4'd2, 4'd4);
    send_op(bmsd_pkg::OP_MERGE, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 4'hf);
    send_op(bmsd_pkg::OP_SPLIT, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 4'd1);
    send_op(bmsd_pkg::OP_SPLIT, 12'd0, 12'd0, 12'd0, 12'd0, 4'd1, 4'd3);
    send_op(bmsd_pkg::OP_SPLIT, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 4'd4);
    // unknown operation codes
    for (int code = int'(bmsd_pkg::OP_SPLIT) + 1; code < 8; code++)
      send_op(3'(code), 12'hfff, 12'hfff, 12'hfff, 12'hfff, 4'hf, 4'hf);
    send_op(bmsd_pkg::OP_CLEAR, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 4'hf, 4'hf);
    send_op(bmsd_pkg::OP_SPLIT, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 4'd1);

    // random phases, each under its own threshold, extremes included
    phase_threshold[0] = 24'($urandom_range(1, 255));
    phase_threshold[1] = 24'hffffff;
    phase_threshold[2] = 24'($urandom_range(256, 65535));
    phase_threshold[3] = 24'($urandom);
    phase_threshold[4] = 24'd0;
    phase_threshold[5] = 24'($urandom_range(1, 40));
    foreach (phase_threshold[p]) begin
      write_threshold(phase_threshold[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_scene();
    end

    wait_idle();
    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("blob_merge_split_detector_top verification clean");
    end else begin
      $display("blob_merge_split_detector_top verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("blob_merge_split_detector_top verification failed");
    $finish;
  end

endmodule
